// ===== src/bloc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bloc_pkg;

  // frame store geometry
  localparam int unsigned MAX_OVERLAY_WIDTH  = 512;
  localparam int unsigned MAX_OVERLAY_HEIGHT = 512;
  localparam int unsigned STORE_DEPTH        = MAX_OVERLAY_WIDTH * MAX_OVERLAY_HEIGHT;
  localparam int unsigned ADDR_W             = 18;

  // field widths
  localparam int unsigned COLOR_W = 24;
  localparam int unsigned DIM_W   = 10;
  localparam int unsigned POS_W   = 12;
  localparam int unsigned CRD_W   = 14;
  localparam int unsigned PROD_W  = 2 * DIM_W;
  localparam int unsigned CFG_IDX_W = 3;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // register reset values
  localparam logic [COLOR_W-1:0] BACKGROUND_RST = 24'd1;
  localparam logic [COLOR_W-1:0] EMPTY_RST      = 24'd1;
  localparam logic [DIM_W-1:0]   ORIGIN_RST     = 10'd256;
  localparam logic [DIM_W-1:0]   SIZE_RST       = 10'd512;

  typedef enum logic [1:0] {
    OP_FILL      = 2'd0,
    OP_COMPOSITE = 2'd1,
    OP_READ      = 2'd2
  } opcode_e_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SKIP = 2'd1,
    ST_OOB  = 2'd2
  } status_e_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BACKGROUND = 3'd0,
    CFG_EMPTY      = 3'd1,
    CFG_ORIGIN_X   = 3'd2,
    CFG_ORIGIN_Y   = 3'd3,
    CFG_WIDTH      = 3'd4,
    CFG_HEIGHT     = 3'd5
  } cfg_reg_e_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADDR,
    S_READ,
    S_MOD
  } back_state_e_t;

  typedef struct packed {
    logic [1:0]              opcode;
    logic                    pixel_on;
    logic [DIM_W-1:0]        col;
    logic [DIM_W-1:0]        row;
    logic signed [POS_W-1:0] layer_pos_x;
    logic signed [POS_W-1:0] layer_pos_y;
    logic [DIM_W-1:0]        layer_width;
    logic [DIM_W-1:0]        layer_height;
    logic [COLOR_W-1:0]      layer_color;
    logic                    layer_enabled;
    logic                    last_of_frame;
  } in_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [ADDR_W-1:0]  address;
    logic               wrote;
    logic [1:0]         status;
    logic               frame_done;
  } out_item_t;

  // register set as seen by front and back, sizes already clipped
  typedef struct packed {
    logic [COLOR_W-1:0] background_color;
    logic [COLOR_W-1:0] empty_color;
    logic [DIM_W-1:0]   origin_x;
    logic [DIM_W-1:0]   origin_y;
    logic [DIM_W-1:0]   width_eff;
    logic [DIM_W-1:0]   height_eff;
  } cfg_t;

  // classified operation handed from front to back
  typedef struct packed {
    logic [1:0]         opcode;
    logic               pixel_on;
    logic [COLOR_W-1:0] layer_color;
    logic [1:0]         status;
    logic               frame_done;
    logic [DIM_W-1:0]   x;
    logic [DIM_W-1:0]   y;
  } job_t;

  // limit a size register to the store dimension
  function automatic logic [DIM_W-1:0] clip_dim(input logic [DIM_W-1:0] v,
                                                 input int unsigned lim);
    logic [DIM_W-1:0] res;
    res = v;
    if (int'(v) > int'(lim)) begin
      res = DIM_W'(lim);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== src/binary_layer_overlay_compositor.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake              payload
// in_       input      in_valid / in_stall    in_data   (in_item_t)
// out_      output     out_valid / out_stall  out_data  (out_item_t)
// cfg_      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// an item passes the front stage register, the queue and the back sequencer states (pop,
// address multiply, store read, modify and write); modify holds while the output stalls
// the sequencer pops a new item only after the read-modify-write of the single-port store
// the front keeps taking items while the four-entry queue has room
// synchronous active-low reset clears control state, the store is not cleared
// a stalled result holds in the output register; cfg_ready is always high

module binary_layer_overlay_compositor import bloc_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COLOR_W-1:0]   cfg_data
);

  logic [COLOR_W-1:0] background_r;
  logic [COLOR_W-1:0] empty_r;
  logic [DIM_W-1:0]   origin_x_r;
  logic [DIM_W-1:0]   origin_y_r;
  logic [DIM_W-1:0]   width_r;
  logic [DIM_W-1:0]   height_r;
  cfg_t               cfg;
  logic               cfg_we;
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  job_t               q_wdata;
  job_t               q_rdata;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      background_r <= BACKGROUND_RST;
      empty_r      <= EMPTY_RST;
      origin_x_r   <= ORIGIN_RST;
      origin_y_r   <= ORIGIN_RST;
      width_r      <= SIZE_RST;
      height_r     <= SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BACKGROUND: background_r <= cfg_data;
        CFG_EMPTY:      empty_r      <= cfg_data;
        CFG_ORIGIN_X:   origin_x_r   <= cfg_data[DIM_W-1:0];
        CFG_ORIGIN_Y:   origin_y_r   <= cfg_data[DIM_W-1:0];
        CFG_WIDTH:      width_r      <= cfg_data[DIM_W-1:0];
        CFG_HEIGHT:     height_r     <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // register view with sizes limited to the store
  always_comb begin
    cfg.background_color = background_r;
    cfg.empty_color      = empty_r;
    cfg.origin_x         = origin_x_r;
    cfg.origin_y         = origin_y_r;
    cfg.width_eff        = clip_dim(width_r, MAX_OVERLAY_WIDTH);
    cfg.height_eff       = clip_dim(height_r, MAX_OVERLAY_HEIGHT);
  end

  bloc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  bloc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  bloc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== src/bloc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bloc_front import bloc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire cfg_t     cfg,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  input  wire logic     q_full,
  output logic          q_push,
  output job_t          q_data
);

  logic                    s1_v_r;
  logic                    s1_v_nxt;
  job_t                    s1_job_r;
  job_t                    job_nxt;
  logic                    in_acc;
  logic signed [CRD_W-1:0] x_comp;
  logic signed [CRD_W-1:0] y_comp;
  logic signed [CRD_W-1:0] x_dst;
  logic signed [CRD_W-1:0] y_dst;
  logic                    is_comp;
  logic                    skip;
  logic                    oob;

  // centred placement of a layer pixel
  always_comb begin
    x_comp = $signed({{(CRD_W-DIM_W){1'b0}}, cfg.origin_x})
           + CRD_W'(in_data.layer_pos_x)
           - $signed({{(CRD_W-DIM_W+1){1'b0}}, in_data.layer_width[DIM_W-1:1]})
           + $signed({{(CRD_W-DIM_W){1'b0}}, in_data.col});
    y_comp = $signed({{(CRD_W-DIM_W){1'b0}}, cfg.origin_y})
           + CRD_W'(in_data.layer_pos_y)
           - $signed({{(CRD_W-DIM_W+1){1'b0}}, in_data.layer_height[DIM_W-1:1]})
           + $signed({{(CRD_W-DIM_W){1'b0}}, in_data.row});
  end

  // classify: skipped layer, bounds
  always_comb begin
    is_comp = (in_data.opcode == OP_COMPOSITE);
    skip    = is_comp && (!in_data.layer_enabled ||
                          (in_data.layer_color == cfg.empty_color));
    x_dst   = is_comp ? x_comp : $signed({{(CRD_W-DIM_W){1'b0}}, in_data.col});
    y_dst   = is_comp ? y_comp : $signed({{(CRD_W-DIM_W){1'b0}}, in_data.row});
    oob     = x_dst[CRD_W-1] || y_dst[CRD_W-1] ||
              (x_dst >= $signed({{(CRD_W-DIM_W){1'b0}}, cfg.width_eff})) ||
              (y_dst >= $signed({{(CRD_W-DIM_W){1'b0}}, cfg.height_eff}));

    job_nxt.opcode      = in_data.opcode;
    job_nxt.pixel_on    = in_data.pixel_on;
    job_nxt.layer_color = in_data.layer_color;
    job_nxt.frame_done  = in_data.last_of_frame;
    job_nxt.x           = x_dst[DIM_W-1:0];
    job_nxt.y           = y_dst[DIM_W-1:0];
    if (skip) begin
      job_nxt.status = ST_SKIP;
    end else if (oob) begin
      job_nxt.status = ST_OOB;
    end else begin
      job_nxt.status = ST_OK;
    end
  end

  // handshake with the queue
  always_comb begin
    in_stall = s1_v_r && q_full;
    in_acc   = in_valid && !in_stall;
    q_push   = s1_v_r && !q_full;
    q_data   = s1_job_r;
    s1_v_nxt = in_acc ? 1'b1 : (q_push ? 1'b0 : s1_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_job_r <= job_nxt;
    end
  end

  // checks
  a_push_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && !in_acc) |=> !s1_v_r)
    else $error("front stage kept an item it had pushed");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_v_r && !q_push))
    else $error("front stalled while its stage could drain");

  a_held_job: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && q_full) |=> $stable(s1_job_r))
    else $error("front stage changed while waiting on the queue");

endmodule

`default_nettype wire

// ===== src/bloc_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bloc_fifo import bloc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_data,
  output logic      full,
  input  wire logic pop,
  output job_t      pop_data,
  output logic      empty
);

  job_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;

  // pointer and fill count update
  always_comb begin
    full     = (count_r == QCNT_W'(QUEUE_DEPTH));
    empty    = (count_r == '0);
    pop_data = slot_r[rd_ptr_r];

    wr_ptr_nxt = wr_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    rd_ptr_nxt = rd_ptr_r;
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // checks
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue fill count out of range");

endmodule

`default_nettype wire

// ===== src/bloc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bloc_back import bloc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cfg_t cfg,
  input  wire logic q_empty,
  input  wire job_t q_data,
  output logic      q_pop,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_item_t out_data
);

  logic [COLOR_W-1:0] mem [STORE_DEPTH];
  back_state_e_t      state_r;
  back_state_e_t      state_nxt;
  job_t               job_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [ADDR_W-1:0]  addr_nxt;
  logic [PROD_W-1:0]  prod;
  logic [COLOR_W-1:0] rdata_r;
  out_item_t          out_r;
  out_item_t          res;
  logic               out_valid_r;
  logic               out_free;
  logic               ld_addr;
  logic               finish;
  logic               mem_we;
  logic               plain;

  // per-byte add, each byte saturating at 255
  function automatic logic [COLOR_W-1:0] sat_add(input logic [COLOR_W-1:0] a,
                                                 input logic [COLOR_W-1:0] b);
    logic [COLOR_W-1:0] r;
    logic [8:0]         s;
    r = '0;
    for (int i = 0; i < COLOR_W / 8; i++) begin
      s = {1'b0, a[i*8 +: 8]} + {1'b0, b[i*8 +: 8]};
      r[i*8 +: 8] = s[8] ? 8'hff : s[7:0];
    end
    return r;
  endfunction

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (!q_empty) state_nxt = S_ADDR;
      S_ADDR:  state_nxt = S_READ;
      S_READ:  state_nxt = S_MOD;
      S_MOD:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    out_free = !out_valid_r || !out_stall;
    q_pop    = (state_r == S_IDLE) && !q_empty;
    ld_addr  = (state_r == S_ADDR);
    finish   = (state_r == S_MOD) && out_free;
    mem_we   = finish && res.wrote;
  end

  // store index, row times pitch plus column
  always_comb begin
    prod     = PROD_W'(job_r.y) * PROD_W'(cfg.width_eff);
    addr_nxt = ADDR_W'(prod + PROD_W'(job_r.x));
  end

  // modify step of the read-modify-write
  always_comb begin
    plain          = (rdata_r == cfg.background_color) || (rdata_r == cfg.empty_color);
    res.color      = '0;
    res.address    = '0;
    res.wrote      = 1'b0;
    res.status     = job_r.status;
    res.frame_done = job_r.frame_done;
    if (job_r.status == ST_OK) begin
      res.address = addr_r;
      case (job_r.opcode)
        OP_FILL: begin
          res.color = cfg.empty_color;
          res.wrote = 1'b1;
        end
        OP_COMPOSITE: begin
          if (!job_r.pixel_on) begin
            res.color = plain ? cfg.background_color : rdata_r;
            res.wrote = plain;
          end else begin
            res.color = plain ? job_r.layer_color : sat_add(rdata_r, job_r.layer_color);
            res.wrote = 1'b1;
          end
        end
        default: begin
          res.color = rdata_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_data;
    end
    if (ld_addr) begin
      addr_r <= addr_nxt;
    end
    if (finish) begin
      out_r <= res;
    end
  end

  // frame store, registered read
  always_ff @(posedge clk) begin
    rdata_r <= mem[addr_r];
    if (mem_we) begin
      mem[addr_r] <= res.color;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  a_wrote_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_r.wrote || (out_r.status == ST_OK)))
    else $error("store write reported on a rejected item");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.status != ST_OK)) |-> (out_r.color == '0 && out_r.address == '0))
    else $error("rejected item carries colour or address");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == S_ADDR))
    else $error("sequencer did not start after taking an item");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_r)))
    else $error("pending result lost or altered");

endmodule

`default_nettype wire

// ===== tb/sv/tb_binary_layer_overlay_compositor.sv =====
`timescale 1ns / 1ps

module tb_binary_layer_overlay_compositor;
  import bloc_pkg::*;

  // spare opcode, decoded by the block as a read
  localparam logic [1:0] OP_SPARE = 2'd3;
  // cycles allowed for the pipeline to empty after the last result
  localparam int SETTLE_CYCLES = 16;
  // results accepted before the long receiver hold-off starts
  localparam int HOLD_AFTER = 250;
  localparam int HOLD_CYCLES = 150;

  typedef struct {
    in_item_t item;
    logic     drain;
  } feed_entry_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COLOR_W-1:0] cfg_data = '0;

  // register copy, starts at the reset values
  logic [COLOR_W-1:0] bg_reg = BACKGROUND_RST;
  logic [COLOR_W-1:0] empty_reg = EMPTY_RST;
  logic [DIM_W-1:0] orig_x_reg = ORIGIN_RST;
  logic [DIM_W-1:0] orig_y_reg = ORIGIN_RST;
  logic [DIM_W-1:0] width_reg = SIZE_RST;
  logic [DIM_W-1:0] height_reg = SIZE_RST;

  // overlay contents as predicted, and entries the stimulus has filled
  logic [COLOR_W-1:0] canvas_model [STORE_DEPTH];
  bit seeded [STORE_DEPTH];

  feed_entry_t pixel_feed[$];
  out_item_t expected_pixels[$];
  out_item_t want_px;

  logic in_taken = 1'b0;
  logic out_taken = 1'b0;
  int feed_gap = 0;
  int feed_calm = 0;
  int stall_left = 0;
  int sink_calm = 0;
  bit long_hold_done = 0;

  int errors = 0;
  int results_seen = 0;
  int settings_used = 1;
  int op_seen [4];
  int stored_writes = 0;
  int skipped = 0;
  int outside = 0;

  binary_layer_overlay_compositor dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // effective frame size, clipped to the store
  function automatic int frame_w();
    return (int'(width_reg) > int'(MAX_OVERLAY_WIDTH)) ? int'(MAX_OVERLAY_WIDTH)
                                                         : int'(width_reg);
  endfunction

  function automatic int frame_h();
    return (int'(height_reg) > int'(MAX_OVERLAY_HEIGHT)) ? int'(MAX_OVERLAY_HEIGHT)
                                                           : int'(height_reg);
  endfunction

  // destination of a transaction; returns 1 when it lies inside the frame
  function automatic logic locate(input in_item_t it, output logic [ADDR_W-1:0] addr);
    int x, y, w, h, px, py;
    w = frame_w();
    h = frame_h();
    x = int'(it.col);
    y = int'(it.row);
    addr = '0;
    if (it.opcode == OP_COMPOSITE) begin
      px = int'($signed(it.layer_pos_x));
      py = int'($signed(it.layer_pos_y));
      x = int'(orig_x_reg) + px - int'(it.layer_width) / 2 + x;
      y = int'(orig_y_reg) + py - int'(it.layer_height) / 2 + y;
    end
    if (x < 0 || y < 0 || x >= w || y >= h) return 1'b0;
    addr = ADDR_W'(y * w + x);
    return 1'b1;
  endfunction

  function automatic logic is_skipped(in_item_t it);
    return it.opcode == OP_COMPOSITE && (!it.layer_enabled || it.layer_color == empty_reg);
  endfunction

  // per-byte additive blend, each byte clamped at full scale
  function automatic logic [COLOR_W-1:0] sat_blend(logic [COLOR_W-1:0] a,
                                                   logic [COLOR_W-1:0] b);
    logic [COLOR_W-1:0] r;
    logic [8:0] s;
    int k;
    for (k = 0; k < 3; k++) begin
      s = {1'b0, a[8*k +: 8]} + {1'b0, b[8*k +: 8]};
      r[8*k +: 8] = s[8] ? 8'hFF : s[7:0];
    end
    return r;
  endfunction

  // predicted result of one transaction, updating the overlay copy
  function automatic out_item_t composite_pixel(in_item_t it);
    out_item_t r;
    logic [ADDR_W-1:0] a;
    logic [COLOR_W-1:0] cur;
    logic plain;
    r = '0;
    r.frame_done = it.last_of_frame;
    if (is_skipped(it)) begin
      r.status = ST_SKIP;
      return r;
    end
    if (!locate(it, a)) begin
      r.status = ST_OOB;
      return r;
    end
    r.address = a;
    r.status = ST_OK;
    case (it.opcode)
      OP_FILL: begin
        r.color = empty_reg;
        r.wrote = 1'b1;
      end
      OP_COMPOSITE: begin
        cur = canvas_model[a];
        plain = (cur == bg_reg) || (cur == empty_reg);
        if (!it.pixel_on) begin
          r.color = plain ? bg_reg : cur;
          r.wrote = plain;
        end else begin
          r.color = plain ? it.layer_color : sat_blend(cur, it.layer_color);
          r.wrote = 1'b1;
        end
      end
      default: r.color = canvas_model[a];
    endcase
    if (r.wrote) canvas_model[a] = r.color;
    return r;
  endfunction

  // idle cycles for one transaction, with occasional runs of none at all
  function automatic int draw_pause(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm = 30;
    return $urandom_range(0, 6);
  endfunction

  function automatic in_item_t random_item();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t make_op(logic [1:0] op, int c, int r);
    in_item_t it;
    it = random_item();
    it.opcode = op;
    it.col = DIM_W'(c);
    it.row = DIM_W'(r);
    it.layer_enabled = 1'b1;
    it.last_of_frame = 1'b0;
    return it;
  endfunction

  // place the layer so that its pixel lands on overlay column x, row y
  function automatic in_item_t aim_at(in_item_t base, int x, int y);
    in_item_t it;
    it = base;
    it.opcode = OP_COMPOSITE;
    it.layer_pos_x = POS_W'(x - int'(orig_x_reg) + int'(base.layer_width) / 2
                            - int'(base.col));
    it.layer_pos_y = POS_W'(y - int'(orig_y_reg) + int'(base.layer_height) / 2
                            - int'(base.row));
    return it;
  endfunction

  function automatic in_item_t shade(int x, int y, logic pix, logic [COLOR_W-1:0] c);
    in_item_t it;
    it = make_op(OP_COMPOSITE, $urandom_range(0, 1023), $urandom_range(0, 1023));
    it.pixel_on = pix;
    it.layer_color = c;
    return aim_at(it, x, y);
  endfunction

  function automatic logic [COLOR_W-1:0] pick_color();
    case ($urandom_range(0, 7))
      0: return empty_reg;
      1: return bg_reg;
      2: return 24'hFFFFFF;
      3: return 24'h000000;
      4: return COLOR_W'($urandom | 32'h808080);
      default: return COLOR_W'($urandom);
    endcase
  endfunction

  // queue a transaction; anything that would read an unfilled entry fills it instead
  task automatic push_pixel(in_item_t it, logic drain);
    feed_entry_t e;
    logic [ADDR_W-1:0] a;
    logic inb;
    inb = locate(it, a) && !is_skipped(it);
    if (inb && it.opcode != OP_FILL && !seeded[a]) begin
      it.opcode = OP_FILL;
      it.col = DIM_W'(int'(a) % frame_w());
      it.row = DIM_W'(int'(a) / frame_w());
    end
    if (inb && it.opcode == OP_FILL) seeded[a] = 1;
    e.item = it;
    e.drain = drain;
    pixel_feed.push_back(e);
  endtask

  task automatic wait_idle();
    while (pixel_feed.size() != 0 || expected_pixels.size() != 0 || in_valid)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_reg(cfg_reg_e_t idx, logic [COLOR_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_BACKGROUND: bg_reg = val;
      CFG_EMPTY:      empty_reg = val;
      CFG_ORIGIN_X:   orig_x_reg = val[DIM_W-1:0];
      CFG_ORIGIN_Y:   orig_y_reg = val[DIM_W-1:0];
      CFG_WIDTH:      width_reg = val[DIM_W-1:0];
      CFG_HEIGHT:     height_reg = val[DIM_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one register setting followed by random traffic around a small hot window
  task automatic run_phase(logic [COLOR_W-1:0] bg, logic [COLOR_W-1:0] emp,
                           logic [COLOR_W-1:0] ox, logic [COLOR_W-1:0] oy,
                           logic [COLOR_W-1:0] wd, logic [COLOR_W-1:0] ht, int count);
    int w, h, hx, hy, hw, hh, x, y, pick, n;
    in_item_t it;
    wait_idle();
    program_reg(CFG_BACKGROUND, bg);
    program_reg(CFG_EMPTY, emp);
    program_reg(CFG_ORIGIN_X, ox);
    program_reg(CFG_ORIGIN_Y, oy);
    program_reg(CFG_WIDTH, wd);
    program_reg(CFG_HEIGHT, ht);
    settings_used++;
    w = frame_w();
    h = frame_h();
    hw = (w < 6) ? w : 6;
    hh = (h < 4) ? h : 4;
    hx = 0;
    hy = 0;
    if (w > 0 && h > 0) begin
      hx = $urandom_range(0, w - hw);
      hy = $urandom_range(0, h - hh);
    end
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (w == 0 || h == 0 || pick < 20) begin
        it = random_item();
      end else begin
        x = hx + $urandom_range(0, hw - 1);
        y = hy + $urandom_range(0, hh - 1);
        if (pick < 35) begin
          it = make_op(OP_FILL, x, y);
        end else if (pick < 80) begin
          it = shade(x, y, 1'($urandom_range(0, 1)), pick_color());
          if ($urandom_range(0, 15) == 0) it.layer_enabled = 1'b0;
          it.last_of_frame = ($urandom_range(0, 31) == 0);
        end else begin
          it = make_op(($urandom_range(0, 3) == 0) ? OP_SPARE : OP_READ, x, y);
        end
      end
      push_pixel(it, n == count / 2);
    end
  endtask

  // input driver: holds each transaction until taken, then waits its drawn gap
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      feed_gap = 0;
    end else if (!in_valid || in_taken) begin
      if (feed_gap > 0) begin
        feed_gap--;
        in_valid <= 1'b0;
      end else if (pixel_feed.size() != 0 &&
                   !(pixel_feed[0].drain && expected_pixels.size() != 0)) begin
        in_data <= pixel_feed[0].item;
        in_valid <= 1'b1;
        void'(pixel_feed.pop_front());
        feed_gap = draw_pause(feed_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result sink back-pressure, with one long hold-off to fill the block
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (!long_hold_done && results_seen >= HOLD_AFTER) begin
        long_hold_done = 1;
        stall_left = HOLD_CYCLES;
      end else if (out_taken) begin
        stall_left = draw_pause(sink_calm);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // sample both channels: predict taken inputs, compare taken results
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      out_taken <= out_valid && !out_stall;
      if (in_valid && !in_stall) begin
        expected_pixels.push_back(composite_pixel(in_data));
        op_seen[int'(in_data.opcode)]++;
      end
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          $error("result with no transaction outstanding: %p", out_data);
          errors++;
        end else begin
          want_px = expected_pixels.pop_front();
          results_seen++;
          if (want_px.wrote) stored_writes++;
          if (want_px.status == ST_SKIP) skipped++;
          if (want_px.status == ST_OOB) outside++;
          if (out_data.color !== want_px.color) begin
            $error("color: expected %h, got %h", want_px.color, out_data.color);
            errors++;
          end
          if (out_data.address !== want_px.address) begin
            $error("address: expected %h, got %h", want_px.address, out_data.address);
            errors++;
          end
          if (out_data.wrote !== want_px.wrote) begin
            $error("wrote: expected %b, got %b", want_px.wrote, out_data.wrote);
            errors++;
          end
          if (out_data.status !== want_px.status) begin
            $error("status: expected %0d, got %0d", want_px.status, out_data.status);
            errors++;
          end
          if (out_data.frame_done !== want_px.frame_done) begin
            $error("frame_done: expected %b, got %b", want_px.frame_done,
                   out_data.frame_done);
            errors++;
          end
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    in_item_t it;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // fills at the frame corners and one beyond them
    push_pixel(make_op(OP_FILL, 0, 0), 1'b0);
    push_pixel(make_op(OP_FILL, 511, 511), 1'b0);
    push_pixel(make_op(OP_FILL, 511, 0), 1'b0);
    push_pixel(make_op(OP_FILL, 1023, 1023), 1'b0);
    // reads inside and outside the frame, spare opcode as a read
    push_pixel(make_op(OP_READ, 511, 0), 1'b0);
    push_pixel(make_op(OP_SPARE, 511, 511), 1'b0);
    push_pixel(make_op(OP_READ, 512, 3), 1'b0);
    // zero pixel on an empty entry, then set pixels on plain and coloured entries
    push_pixel(shade(0, 0, 1'b0, 24'h00FF80), 1'b0);
    push_pixel(shade(0, 0, 1'b1, 24'hF0F0F0), 1'b0);
    push_pixel(shade(0, 0, 1'b1, 24'h0A0F20), 1'b0);
    // zero pixel on a coloured entry leaves it alone
    push_pixel(shade(0, 0, 1'b0, 24'h123456), 1'b0);
    push_pixel(shade(511, 511, 1'b1, 24'hFFFFFF), 1'b0);
    push_pixel(shade(511, 511, 1'b1, 24'h000000), 1'b0);
    // widest layer, far corner of its image
    it = make_op(OP_COMPOSITE, 1023, 1023);
    it.layer_width = 10'd1023;
    it.layer_height = 10'd1023;
    it.pixel_on = 1'b1;
    it.layer_color = 24'h404040;
    push_pixel(aim_at(it, 511, 0), 1'b0);
    // skipped layers: disabled, and painted in the empty colour
    it = shade(0, 0, 1'b1, 24'h777777);
    it.layer_enabled = 1'b0;
    push_pixel(it, 1'b0);
    push_pixel(shade(0, 0, 1'b1, empty_reg), 1'b0);
    // layer positions at their extremes land outside the frame
    it = make_op(OP_COMPOSITE, 0, 0);
    it.layer_color = 24'h00AA00;
    it.layer_pos_x = -12'sd2048;
    it.layer_pos_y = 12'sd2047;
    push_pixel(it, 1'b0);
    it.layer_pos_x = 12'sd2047;
    it.layer_pos_y = -12'sd2048;
    push_pixel(it, 1'b0);
    // end of frame marker on a read
    it = make_op(OP_READ, 0, 0);
    it.last_of_frame = 1'b1;
    push_pixel(it, 1'b0);

    run_phase(24'h000000, 24'hFFFFFF, 24'd8, 24'd4, 24'd16, 24'd8, 400);
    run_phase(COLOR_W'($urandom), COLOR_W'($urandom), 24'd0, 24'd0, 24'd1, 24'd1, 150);
    run_phase(24'h0000FF, 24'h00FF00, 24'hFC0100, 24'h3C0100, 24'hABC000, 24'hFFFFFF, 100);
    run_phase(24'hFFFFFF, 24'h000000, 24'd1023, 24'd1023, 24'd1023, 24'd512, 400);
    run_phase(COLOR_W'($urandom), COLOR_W'($urandom),
              COLOR_W'($urandom_range(0, 1023)), COLOR_W'($urandom_range(0, 1023)),
              COLOR_W'($urandom_range(1, 512)), COLOR_W'($urandom_range(1, 512)), 400);
    run_phase(COLOR_W'($urandom), 24'h010101, 24'd300, 24'd0, 24'd512, 24'd1, 200);
    run_phase(BACKGROUND_RST, EMPTY_RST, 24'(ORIGIN_RST), 24'(ORIGIN_RST),
              24'(SIZE_RST), 24'(SIZE_RST), 300);

    wait_idle();
    if (expected_pixels.size() != 0) errors++;

    $display("checked %0d results over %0d register settings: %0d fills, %0d composites,",
             results_seen, settings_used, op_seen[0], op_seen[1]);
    $display("%0d reads (%0d on the spare code), %0d skipped, %0d outside, %0d stored",
             op_seen[2] + op_seen[3], op_seen[3], skipped, outside, stored_writes);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
